FILE: rtl/core/pfc_pkg.sv
// Shared types, letter codes and square lookup functions for the Playfair digraph cipher.
// No dependencies; every module of the block imports this package.
package pfc_pkg;

	localparam int unsigned Side   = 5;
	localparam int unsigned Cells  = Side * Side;
	localparam int unsigned QDepth = 4;

	localparam logic [4:0] CODE_I = 5'd8;
	localparam logic [4:0] CODE_J = 5'd9;
	localparam logic [4:0] CODE_Q = 5'd16;
	localparam logic [4:0] CODE_X = 5'd23;
	localparam logic [4:0] CODE_Z = 5'd25;

	typedef enum logic [1:0] {
		REG_SQ_LOW    = 2'd0,
		REG_SQ_MID    = 2'd1,
		REG_SQ_HIGH   = 2'd2,
		REG_DIRECTION = 2'd3
	} reg_index_t;

	// cell k of the square sits at element k, row major
	typedef logic [Cells-1:0][4:0] square_t;

	typedef struct packed {
		logic [4:0] a;
		logic [4:0] b;
		logic       fin;
	} digraph_t;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
	} cell_pos_t;

	typedef struct packed {
		logic held_valid;
	} front_status_t;

	typedef struct packed {
		logic nonempty;
		logic space2;
	} queue_status_t;

	// highest matching cell wins; no match gives cell 0
	function automatic cell_pos_t find_cell(square_t sq, logic [4:0] letter);
		cell_pos_t pos;
		pos = '0;
		for (int r = 0; r < Side; r++) begin
			for (int c = 0; c < Side; c++) begin
				if (sq[r*Side+c] == letter) begin
					pos.row = 3'(r);
					pos.col = 3'(c);
				end
			end
		end
		return pos;
	endfunction

	// advance one place around the row or column, backward on decrypt
	function automatic logic [2:0] shift_pos(logic [2:0] v, logic dir);
		logic [2:0] r;
		if (!dir) begin
			r = (v == 3'(Side - 1)) ? 3'd0 : v + 3'd1;
		end else begin
			r = (v == 3'd0) ? 3'(Side - 1) : v - 3'd1;
		end
		return r;
	endfunction

	function automatic logic [4:0] cell_at(square_t sq, cell_pos_t p);
		logic [4:0] idx;
		idx = 5'(p.row) * 5'(Side) + 5'(p.col);
		return sq[idx];
	endfunction

endpackage

FILE: rtl/core/pfc_front.sv
// Front end: J folding, held-letter pairing, filler insertion and end-of-text padding.
// Depends on pfc_pkg; pushes up to two digraphs per accepted word into pfc_queue.
module pfc_front
	import pfc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [4:0]    letter_in,
	input  logic          text_end,
	input  queue_status_t q_status,
	output logic [1:0]    push_n,
	output digraph_t      push_d0,
	output digraph_t      push_d1,
	output front_status_t status
);

	logic [4:0] held_q;
	logic       held_vld_q;
	logic [4:0] c;
	logic [4:0] held_d;
	logic       hv_d;
	logic       has0;
	logic       hasz;
	logic       acc;
	digraph_t   p0;
	digraph_t   pz;

	assign in_ready = q_status.space2;
	assign acc      = in_valid && in_ready;
	assign status.held_valid = held_vld_q;

	always_comb begin
		c      = (letter_in == CODE_J) ? CODE_I : letter_in;
		held_d = held_q;
		hv_d   = held_vld_q;
		has0   = 1'b0;
		p0     = '0;
		if (held_vld_q && c == held_q) begin
			// repeated letter: pad with filler, keep letter for next pair
			p0.a   = held_q;
			p0.b   = (c == CODE_X) ? CODE_Q : CODE_X;
			has0   = 1'b1;
			held_d = c;
			hv_d   = 1'b1;
		end else if (held_vld_q) begin
			p0.a = held_q;
			p0.b = c;
			has0 = 1'b1;
			hv_d = 1'b0;
		end else begin
			held_d = c;
			hv_d   = 1'b1;
		end
		hasz   = text_end && hv_d;
		pz.a   = held_d;
		pz.b   = CODE_Z;
		pz.fin = 1'b1;
		p0.fin = text_end && !hasz;
		if (text_end) begin
			hv_d = 1'b0;
		end
		if (has0) begin
			push_d0 = p0;
			push_d1 = pz;
		end else begin
			push_d0 = pz;
			push_d1 = pz;
		end
		push_n = acc ? ({1'b0, has0} + {1'b0, hasz}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_vld_q <= 1'b0;
		end else if (acc) begin
			held_q     <= held_d;
			held_vld_q <= hv_d;
		end
	end

endmodule

FILE: rtl/core/pfc_queue.sv
// Digraph queue between front and back: four entries, up to two pushes and one pop a cycle.
// Depends on pfc_pkg.
module pfc_queue
	import pfc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_n,
	input  digraph_t      push_d0,
	input  digraph_t      push_d1,
	input  logic          pop,
	output digraph_t      head,
	output queue_status_t status
);

	localparam int unsigned PtrW = $clog2(QDepth);
	localparam int unsigned CntW = $clog2(QDepth + 1);

	digraph_t          mem_q [QDepth];
	logic [PtrW-1:0]   wp_q;
	logic [PtrW-1:0]   rp_q;
	logic [CntW-1:0]   cnt_q;

	assign head            = mem_q[rp_q];
	assign status.nonempty = (cnt_q != '0);
	assign status.space2   = (cnt_q <= CntW'(QDepth - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= push_d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp_q + PtrW'(1)] <= push_d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PtrW'(push_n);
			rp_q  <= rp_q + PtrW'(pop);
			cnt_q <= cnt_q + CntW'(push_n) - CntW'(pop);
		end
	end

endmodule

FILE: rtl/core/pfc_back.sv
// Back end: square lookup, row/column/rectangle rules, and two-letter output register.
// Depends on pfc_pkg; pops digraphs from pfc_queue.
module pfc_back
	import pfc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  square_t       square,
	input  logic          dir,
	input  queue_status_t q_status,
	input  digraph_t      head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [4:0]    letter_out,
	output logic          final_out
);

	// stage 1: digraph awaiting lookup
	logic      vld_s1;
	digraph_t  dg_s1;
	// stage 2: looked-up positions
	logic      vld_s2;
	cell_pos_t p1_s2;
	cell_pos_t p2_s2;
	logic      fin_s2;
	// output word pair
	logic      out_vld_q;
	logic      out_sel_q;
	logic [4:0] l0_q;
	logic [4:0] l1_q;
	logic      fin_q;

	logic      out_free;
	logic      s2_free;
	logic      s1_free;
	cell_pos_t n1;
	cell_pos_t n2;

	assign out_free = !out_vld_q || (out_sel_q && out_ready);
	assign s2_free  = !vld_s2 || out_free;
	assign s1_free  = !vld_s1 || s2_free;
	assign pop      = q_status.nonempty && s1_free;

	assign out_valid  = out_vld_q;
	assign letter_out = out_sel_q ? l1_q : l0_q;
	assign final_out  = out_sel_q && fin_q;

	always_comb begin
		n1 = p1_s2;
		n2 = p2_s2;
		if (p1_s2.row == p2_s2.row) begin
			n1.col = shift_pos(p1_s2.col, dir);
			n2.col = shift_pos(p2_s2.col, dir);
		end else if (p1_s2.col == p2_s2.col) begin
			n1.row = shift_pos(p1_s2.row, dir);
			n2.row = shift_pos(p2_s2.row, dir);
		end else begin
			n1.row = p2_s2.row;
			n2.row = p1_s2.row;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dg_s1 <= head;
		end
		if (vld_s1 && s2_free) begin
			p1_s2  <= find_cell(square, dg_s1.a);
			p2_s2  <= find_cell(square, dg_s1.b);
			fin_s2 <= dg_s1.fin;
		end
		if (vld_s2 && out_free) begin
			l0_q  <= cell_at(square, n1);
			l1_q  <= cell_at(square, n2);
			fin_q <= fin_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			out_sel_q <= 1'b0;
		end else begin
			if (s1_free) begin
				vld_s1 <= pop;
			end
			if (s2_free) begin
				vld_s2 <= vld_s1;
			end
			if (out_free) begin
				out_vld_q <= vld_s2;
				out_sel_q <= 1'b0;
			end else if (out_ready) begin
				// first letter taken, show the second
				out_sel_q <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: configuration registers, front, queue, back.
// Depends on pfc_pkg, pfc_front, pfc_queue and pfc_back.
//
// Letters (0 = A .. 25 = Z) enter one word per cycle while in_ready is high; J folds to I,
// a repeated letter gets an X filler (Q after X), and an unpaired letter at text end is
// padded with Z. Each digraph is enciphered against the 5x5 square in the three cell
// registers (direction 0 encrypts, 1 decrypts) and leaves as two letter words, final_out
// marking the last one of the text. The single output port sets the rate: one letter a
// cycle while out_ready is high, so plain text without fillers streams at one input
// letter a cycle. The input takes a word whenever the four-entry digraph queue has two
// free entries; a completed pair passes the queue, stage 1, stage 2 and the output
// register. Configuration is taken every cycle and must only be written while idle.
module playfair_digraph_cipher
	import pfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [44:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  letter_in,
	input  logic        text_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  letter_out,
	output logic        final_out
);

	logic [44:0]   sq_low_q;
	logic [39:0]   sq_mid_q;
	logic [39:0]   sq_high_q;
	logic          dir_q;
	square_t       square;
	queue_status_t q_status;
	front_status_t f_status;
	logic [1:0]    push_n;
	digraph_t      push_d0;
	digraph_t      push_d1;
	digraph_t      head;
	logic          q_pop;

	assign cfg_ready = 1'b1;
	assign square    = {sq_high_q, sq_mid_q, sq_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_low_q  <= '0;
			sq_mid_q  <= '0;
			sq_high_q <= '0;
			dir_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_SQ_LOW:    sq_low_q  <= cfg_data;
				REG_SQ_MID:    sq_mid_q  <= cfg_data[39:0];
				REG_SQ_HIGH:   sq_high_q <= cfg_data[39:0];
				REG_DIRECTION: dir_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.letter_in(letter_in),
		.text_end (text_end),
		.q_status (q_status),
		.push_n   (push_n),
		.push_d0  (push_d0),
		.push_d1  (push_d1),
		.status   (f_status)
	);

	pfc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.push_d0(push_d0),
		.push_d1(push_d1),
		.pop    (q_pop),
		.head   (head),
		.status (q_status)
	);

	pfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.square    (square),
		.dir       (dir_q),
		.q_status  (q_status),
		.head      (head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.letter_out(letter_out),
		.final_out (final_out)
	);

	a_end_clears_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && text_end |=> !f_status.held_valid)
		else $error("held letter survived end of text");

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> in_valid && in_ready)
		else $error("queue push without accepted word");

	a_pair_completes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && f_status.held_valid |-> push_n != 2'd0)
		else $error("completed digraph not queued");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_status.nonempty)
		else $error("pop from empty queue");

endmodule
